@@ rtl/md5cb_pkg.sv @@
// ----------------------------------------------------------------------------
// md5cb_pkg
// Shared types, constants and tables of the MD5 digest character unit.
// ----------------------------------------------------------------------------
package md5cb_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [6:0] digest_char;
    logic       char_last;
  } out_item_t;

  // Request from the sequencer to the round engine, and its reply.
  typedef struct packed {
    logic start;
  } rnd_ctrl_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [3:0] word_sel;
  } rnd_stat_t;

  localparam int unsigned CharCount = 22;
  localparam logic [7:0]  PadByte   = 8'h80;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index used by each round.
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [3:0] g;
    logic [7:0] t;
    t = 8'd0;
    case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: begin t = 8'(5 * r + 1); g = t[3:0]; end
      2'd2: begin t = 8'(3 * r + 5); g = t[3:0]; end
      default: begin t = 8'(7 * r); g = t[3:0]; end
    endcase
    return g;
  endfunction

  // ASCII code of each of the 64 output symbols.
  function automatic logic [6:0] symbol(input logic [5:0] v);
    logic [6:0] c;
    case (v)
      6'd0: c = 7'h54;  6'd1: c = 7'h53;  6'd2: c = 7'h47;  6'd3: c = 7'h38;
      6'd4: c = 7'h49;  6'd5: c = 7'h6e;  6'd6: c = 7'h63;  6'd7: c = 7'h57;
      6'd8: c = 7'h33;  6'd9: c = 7'h48;  6'd10: c = 7'h46; 6'd11: c = 7'h4b;
      6'd12: c = 7'h6f; 6'd13: c = 7'h6b; 6'd14: c = 7'h4f; 6'd15: c = 7'h67;
      6'd16: c = 7'h37; 6'd17: c = 7'h39; 6'd18: c = 7'h71; 6'd19: c = 7'h7a;
      6'd20: c = 7'h65; 6'd21: c = 7'h43; 6'd22: c = 7'h6d; 6'd23: c = 7'h5a;
      6'd24: c = 7'h73; 6'd25: c = 7'h32; 6'd26: c = 7'h79; 6'd27: c = 7'h42;
      6'd28: c = 7'h59; 6'd29: c = 7'h45; 6'd30: c = 7'h51; 6'd31: c = 7'h56;
      6'd32: c = 7'h41; 6'd33: c = 7'h55; 6'd34: c = 7'h78; 6'd35: c = 7'h52;
      6'd36: c = 7'h35; 6'd37: c = 7'h72; 6'd38: c = 7'h62; 6'd39: c = 7'h77;
      6'd40: c = 7'h69; 6'd41: c = 7'h34; 6'd42: c = 7'h50; 6'd43: c = 7'h40;
      6'd44: c = 7'h6a; 6'd45: c = 7'h4d; 6'd46: c = 7'h44; 6'd47: c = 7'h4c;
      6'd48: c = 7'h74; 6'd49: c = 7'h70; 6'd50: c = 7'h76; 6'd51: c = 7'h61;
      6'd52: c = 7'h64; 6'd53: c = 7'h30; 6'd54: c = 7'h66; 6'd55: c = 7'h5f;
      6'd56: c = 7'h4a; 6'd57: c = 7'h31; 6'd58: c = 7'h68; 6'd59: c = 7'h6c;
      6'd60: c = 7'h4e; 6'd61: c = 7'h36; 6'd62: c = 7'h75; default: c = 7'h58;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/md5cb_round.sv @@
// ----------------------------------------------------------------------------
// md5cb_round
// Shared MD5 round unit: one round per cycle over a 64-round compression.
// ----------------------------------------------------------------------------
module md5cb_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  md5cb_pkg::rnd_ctrl_t ctrl_i,
  input  logic [31:0]          msg_word_i,
  input  logic [127:0]         chain_i,
  output md5cb_pkg::rnd_stat_t stat_o,
  output logic [127:0]         sum_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  r_q, r_d;
  logic [5:0]  r_nx;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;
  logic [31:0] f, t;
  logic [4:0]  s;
  logic [63:0] rot;

  always_comb begin
    case (r_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (d_q & b_q) | (~d_q & c_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    t   = f + a_q + md5cb_pkg::md5_k(r_q) + msg_word_i;
    s   = md5cb_pkg::md5_rot(r_q);
    rot = {t, t} << s;
    // The message word of the next round is fetched ahead, through the registered read.
    r_nx = busy_q ? 6'(r_q + 6'd1) : 6'd0;
    busy_d = busy_q;
    done_d = busy_q && (r_q == 6'd63);
    r_d = r_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    if (ctrl_i.start && !busy_q) begin
      busy_d = 1'b1;
      r_d = 6'd0;
      {a_d, b_d, c_d, d_d} = chain_i;
    end else if (busy_q) begin
      a_d = d_q;
      d_d = c_q;
      c_d = b_q;
      b_d = b_q + rot[63:32];
      r_d = r_q + 6'd1;
      if (r_q == 6'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      r_q    <= 6'd0;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      r_q    <= r_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    end
  end

  // The sum is valid in the cycle after the last round, while done is high.
  assign stat_o.busy     = busy_q;
  assign stat_o.done     = done_q;
  assign stat_o.word_sel = md5cb_pkg::md5_g(r_nx);
  assign sum_o = {chain_i[127:96] + a_q, chain_i[95:64] + b_q,
                  chain_i[63:32] + c_q, chain_i[31:0] + d_q};

endmodule

@@ rtl/md5_custom_base64_digest_unit.sv @@
// ----------------------------------------------------------------------------
// md5_custom_base64_digest_unit
// MD5 over a byte stream, digest emitted as 22 characters of a custom alphabet.
// ----------------------------------------------------------------------------
// A non-final byte is written into the block buffer; a byte that fills a block holds
// the input through the launch of the round unit, its rounds and the fold of the sum.
// A final byte at block position n is followed by pad bytes up to position 63 and a
// compression; when the length does not fit, a second padded block is compressed too.
// The 22 characters then leave at one per cycle as the sink takes them.
// Reset restores the MD5 initial chain values and a zero byte count.
// ----------------------------------------------------------------------------
module md5_custom_base64_digest_unit #(
  parameter int unsigned LENGTH_COUNTER_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  md5cb_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output md5cb_pkg::out_item_t  out_data_o
);

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StComp = 3'd1;  // compression of a block in progress
  localparam logic [2:0] StPad  = 3'd2;  // writing pad bytes, one a cycle
  localparam logic [2:0] StEmit = 3'd3;  // streaming digest characters
  localparam logic [2:0] StWait = 3'd4;  // launch cycle of the round unit

  localparam int unsigned CntW = LENGTH_COUNTER_BITS;

  logic [2:0]      st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [127:0]    chain_q, chain_d;
  logic [5:0]      pos_q, pos_d;      // pad write position
  logic            final_q, final_d;  // the block being built carries the length
  logic            fin_msg_q, fin_msg_d;
  logic            mark_q, mark_d;    // the 0x80 marker is still to be written
  logic [4:0]      ch_q, ch_d;
  logic [127:0]    dig_q, dig_d;      // digest bytes in output order, MSB first

  // Block buffer: a memory of sixteen 32-bit words with byte writes.
  logic [31:0] mem_q [16];
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;
  logic [31:0] rd_q;

  md5cb_pkg::rnd_ctrl_t rctl;
  md5cb_pkg::rnd_stat_t rnd_stat;
  logic [127:0]         sum;

  logic            in_fire, out_fire;
  logic [CntW-1:0] bits;
  logic [7:0]      len_byte;
  logic [127:0]    dig_bytes;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign bits     = cnt_q << 3;

  // The round unit asks for the word of its next round, so the registered
  // read data lines up with the round that uses it.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_byte;
    end
    rd_q <= mem_q[rnd_stat.word_sel];
  end

  md5cb_round u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (rctl),
    .msg_word_i(rd_q),
    .chain_i   (chain_q),
    .stat_o    (rnd_stat),
    .sum_o     (sum)
  );

  // Length byte for pad positions 56 to 63, least significant byte first.
  always_comb begin
    logic [63:0] bx;
    bx = 64'(bits);
    len_byte = bx[8*pos_q[2:0] +: 8];
  end

  // Each chain word goes out little-endian, word A first.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        dig_bytes[127 - 8*(4*i+k) -: 8] = sum[32*(3-i) + 8*k +: 8];
      end
    end
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; chain_d = chain_q; pos_d = pos_q;
    final_d = final_q; fin_msg_d = fin_msg_q; mark_d = mark_q;
    ch_d = ch_q; dig_d = dig_q;
    wr_en = 1'b0; wr_addr = pos_q; wr_byte = 8'h00;
    rctl.start = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_fire) begin
          wr_en = 1'b1;
          wr_addr = cnt_q[5:0];
          wr_byte = in_data_i.data_byte;
          cnt_d = cnt_q + CntW'(1);
          fin_msg_d = in_data_i.is_last;
          mark_d = in_data_i.is_last;
          pos_d = cnt_q[5:0] + 6'd1;
          final_d = 1'b0;
          if (cnt_q[5:0] == 6'd63) begin
            // A full block is compressed first; for a final byte, padding then starts a new one.
            st_d = StWait;
          end else if (in_data_i.is_last) begin
            // The length fits when the marker lands at position 55 or below.
            st_d = StPad;
            final_d = (cnt_q[5:0] < 6'd55);
          end
        end
      end
      StPad: begin
        wr_en = 1'b1;
        if (mark_q) begin
          wr_byte = md5cb_pkg::PadByte;
        end else if (final_q && pos_q >= 6'd56) begin
          wr_byte = len_byte;
        end else begin
          wr_byte = 8'h00;
        end
        mark_d = 1'b0;
        pos_d = pos_q + 6'd1;
        if (pos_q == 6'd63) st_d = StWait;
      end
      StWait: begin
        rctl.start = 1'b1;
        st_d = StComp;
      end
      StComp: begin
        if (rnd_stat.done) begin
          if (final_q) begin
            // Digest complete: latch it and start the next message afresh.
            dig_d = dig_bytes;
            chain_d = {md5cb_pkg::InitA, md5cb_pkg::InitB, md5cb_pkg::InitC,
                       md5cb_pkg::InitD};
            cnt_d = '0;
            ch_d = 5'd0;
            st_d = StEmit;
          end else begin
            chain_d = sum;
            if (fin_msg_q) begin
              // One more block: from position 0, it always has room for the length.
              pos_d = 6'd0;
              final_d = 1'b1;
              st_d = StPad;
            end else begin
              st_d = StIdle;
            end
          end
        end
      end
      StEmit: begin
        if (out_fire) begin
          dig_d = dig_q << 6;
          ch_d = ch_q + 5'd1;
          if (ch_q == 5'(md5cb_pkg::CharCount - 1)) begin
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      chain_q <= {md5cb_pkg::InitA, md5cb_pkg::InitB, md5cb_pkg::InitC, md5cb_pkg::InitD};
      pos_q <= '0;
      final_q <= 1'b0;
      fin_msg_q <= 1'b0;
      mark_q <= 1'b0;
      ch_q <= '0;
      dig_q <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      chain_q <= chain_d;
      pos_q <= pos_d;
      final_q <= final_d;
      fin_msg_q <= fin_msg_d;
      mark_q <= mark_d;
      ch_q <= ch_d;
      dig_q <= dig_d;
    end
  end

  // The top six bits of the shifting digest form the current character; the
  // last one is the final two digest bits followed by zeros shifted in.
  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StEmit);
  assign out_data_o.digest_char = md5cb_pkg::symbol(dig_q[127:122]);
  assign out_data_o.char_last = (ch_q == 5'(md5cb_pkg::CharCount - 1));

  // Assertions.
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_stat.busy |-> !in_ready_o) else $error("input accepted during compression");
  a_no_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_stat.busy |-> !out_valid_o) else $error("output during compression");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.char_last) |=> in_ready_o) else $error("emit did not end");

endmodule
